// File: rtl/sdbc_pkg.sv
// Shared constants, types and helper functions of the sample depth to byte converter.
package sdbc_pkg;

    localparam int SAMPLE_W = 17;
    localparam int PREC_W   = 5;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 3;
    localparam int LAYOUT_W = 2;
    localparam int FLAGS_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [PREC_W-1:0] PREC_MIN  = 5'd1;
    localparam logic [PREC_W-1:0] PREC_MAX  = 5'd16;
    localparam logic [PREC_W-1:0] PREC_BYTE = 5'd8;
    localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYOUT      = 3'd0,
        CFG_FIRST_PREC  = 3'd1,
        CFG_SECOND_PREC = 3'd2,
        CFG_THIRD_PREC  = 3'd3,
        CFG_ALPHA_PREC  = 3'd4,
        CFG_SIGNED      = 3'd5
    } t_cfg_idx;

    // Layout bit positions: bit 1 set for colour, bit 0 set when alpha present
    localparam int LAYOUT_RGB_BIT   = 1;
    localparam int LAYOUT_ALPHA_BIT = 0;

    localparam int FLAG_FIRST  = 0;
    localparam int FLAG_SECOND = 1;
    localparam int FLAG_THIRD  = 2;
    localparam int FLAG_ALPHA  = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [BYTE_W-1:0]          t_byte;
    typedef logic [PREC_W-1:0]          t_prec;

    function automatic t_prec clamp_prec(input t_prec p);
        t_prec r;
        if (p < PREC_MIN) begin
            r = PREC_MIN;
        end else if (p > PREC_MAX) begin
            r = PREC_MAX;
        end else begin
            r = p;
        end
        return r;
    endfunction

    // Repeat the low p bits, MSB first, until 8 bits are filled
    function automatic t_byte replicate(input logic [6:0] m, input logic [2:0] p);
        t_byte r;
        unique case (p)
            3'd1:    r = {8{m[0]}};
            3'd2:    r = {4{m[1:0]}};
            3'd3:    r = {m[2:0], m[2:0], m[2:1]};
            3'd4:    r = {2{m[3:0]}};
            3'd5:    r = {m[4:0], m[4:2]};
            3'd6:    r = {m[5:0], m[5:4]};
            3'd7:    r = {m[6:0], m[6]};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/sdbc_channel.sv
// Per-channel conversion of one sample to an 8-bit byte.
module sdbc_channel
    import sdbc_pkg::*;
(
    input  t_sample i_sample,
    input  t_prec   i_prec_first,
    input  t_prec   i_prec_chan,
    input  logic    i_signed,
    output t_byte   o_byte
);

    logic [SAMPLE_W:0]   pix;
    logic [SAMPLE_W:0]   offset;
    logic [3:0]          sh;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] shifted;
    logic [SAMPLE_W-1:0] half;
    logic [SAMPLE_W:0]   rounded;
    t_byte               shift_byte;

    always_comb begin
        offset = i_signed ? ((SAMPLE_W+1)'(1) << (i_prec_chan - PREC_MIN)) : '0;
        pix    = {i_sample[SAMPLE_W-1], i_sample} + offset;

        mag = pix[SAMPLE_W-1:0];
        sh  = (i_prec_chan > PREC_BYTE) ? 4'(i_prec_chan - PREC_BYTE) : 4'd0;
        if (sh != 4'd0) begin
            shifted = mag >> sh;
            half    = mag >> (sh - 4'd1);
            rounded = {1'b0, shifted} + (SAMPLE_W+1)'(half[0]);
        end else begin
            shifted = mag;
            half    = '0;
            rounded = {1'b0, mag};
        end

        if (pix[SAMPLE_W]) begin
            shift_byte = '0;
        end else if (rounded > (SAMPLE_W+1)'(BYTE_MAX)) begin
            shift_byte = BYTE_MAX;
        end else begin
            shift_byte = rounded[BYTE_W-1:0];
        end

        if (i_prec_first < PREC_BYTE) begin
            o_byte = replicate(pix[6:0], i_prec_first[2:0]);
        end else begin
            o_byte = shift_byte;
        end
    end

endmodule

// File: rtl/sample_depth_to_byte_converter_top.sv
// Sample depth to byte converter: top level with config registers and two-stage stream pipe.
// One pixel per clock sustained while the master side accepts; each pixel passes an input
// register and then a result register, which presents its result. All four channel
// converters work in parallel between those two registers; back-pressure on the master
// side holds the result register and, once the input register is full too, the slave side.
// The user must write config only when the pipe is empty; the block itself does not enforce this.
module sample_depth_to_byte_converter_top
    import sdbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_first[16:0], sample_second[33:17], sample_third[50:34], sample_alpha[67:51]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // byte_zero[7:0], byte_one[15:8], byte_two[23:16], byte_three[31:24], byte_count[34:32]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [LAYOUT_W-1:0] r_layout;
    t_prec               r_prec_first;
    t_prec               r_prec_second;
    t_prec               r_prec_third;
    t_prec               r_prec_alpha;
    logic [FLAGS_W-1:0]  r_signed;

    logic    r_in_valid;
    t_sample r_smp_first;
    t_sample r_smp_second;
    t_sample r_smp_third;
    t_sample r_smp_alpha;

    logic               r_out_valid;
    t_byte              r_byte_zero;
    t_byte              r_byte_one;
    t_byte              r_byte_two;
    t_byte              r_byte_three;
    logic [COUNT_W-1:0] r_byte_count;

    logic  stage_ready;
    t_prec p0, p1, p2, pa;
    t_byte cv_first, cv_second, cv_third, cv_alpha;
    logic  is_rgb, alpha_on;
    t_byte n_byte_one, n_byte_two, n_byte_three;
    logic [COUNT_W-1:0] n_byte_count;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout      <= '0;
            r_prec_first  <= PREC_BYTE;
            r_prec_second <= PREC_BYTE;
            r_prec_third  <= PREC_BYTE;
            r_prec_alpha  <= PREC_BYTE;
            r_signed      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAYOUT:      r_layout      <= i_cfg_data[LAYOUT_W-1:0];
                CFG_FIRST_PREC:  r_prec_first  <= i_cfg_data[PREC_W-1:0];
                CFG_SECOND_PREC: r_prec_second <= i_cfg_data[PREC_W-1:0];
                CFG_THIRD_PREC:  r_prec_third  <= i_cfg_data[PREC_W-1:0];
                CFG_ALPHA_PREC:  r_prec_alpha  <= i_cfg_data[PREC_W-1:0];
                CFG_SIGNED:      r_signed      <= i_cfg_data[FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    assign stage_ready   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || stage_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_smp_first  <= s_axis_tdata[SAMPLE_W-1:0];
            r_smp_second <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            r_smp_third  <= s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            r_smp_alpha  <= s_axis_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
        end
    end

    assign p0 = clamp_prec(r_prec_first);
    assign p1 = clamp_prec(r_prec_second);
    assign p2 = clamp_prec(r_prec_third);
    assign pa = clamp_prec(r_prec_alpha);

    sdbc_channel u_chan_first (
        .i_sample     (r_smp_first),
        .i_prec_first (p0),
        .i_prec_chan  (p0),
        .i_signed     (r_signed[FLAG_FIRST]),
        .o_byte       (cv_first)
    );

    sdbc_channel u_chan_second (
        .i_sample     (r_smp_second),
        .i_prec_first (p0),
        .i_prec_chan  (p1),
        .i_signed     (r_signed[FLAG_SECOND]),
        .o_byte       (cv_second)
    );

    sdbc_channel u_chan_third (
        .i_sample     (r_smp_third),
        .i_prec_first (p0),
        .i_prec_chan  (p2),
        .i_signed     (r_signed[FLAG_THIRD]),
        .o_byte       (cv_third)
    );

    sdbc_channel u_chan_alpha (
        .i_sample     (r_smp_alpha),
        .i_prec_first (p0),
        .i_prec_chan  (pa),
        .i_signed     (r_signed[FLAG_ALPHA]),
        .o_byte       (cv_alpha)
    );

    // Pack bytes by layout; unused slots are zero
    always_comb begin
        is_rgb   = r_layout[LAYOUT_RGB_BIT];
        alpha_on = r_layout[LAYOUT_ALPHA_BIT];
        if (is_rgb) begin
            n_byte_one   = cv_second;
            n_byte_two   = cv_third;
            n_byte_three = alpha_on ? cv_alpha : '0;
        end else begin
            n_byte_one   = alpha_on ? cv_alpha : '0;
            n_byte_two   = '0;
            n_byte_three = '0;
        end
        n_byte_count = COUNT_W'(r_layout) + COUNT_W'(1);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && r_in_valid) begin
            r_byte_zero  <= cv_first;
            r_byte_one   <= n_byte_one;
            r_byte_two   <= n_byte_two;
            r_byte_three <= n_byte_three;
            r_byte_count <= n_byte_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_byte_count, r_byte_three, r_byte_two,
                            r_byte_one, r_byte_zero};

    // A result only appears after a held input transaction
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared without a staged transaction");

    // A stalled result must not drop the staged transaction behind it
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> r_in_valid)
        else $error("staged transaction lost under back-pressure");

    // Single-byte pixels carry zero in the unused bytes
    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_byte_count == COUNT_W'(1)) |->
        (r_byte_one == '0 && r_byte_two == '0 && r_byte_three == '0))
        else $error("unused bytes not zero for gray pixel");

    // Byte count stays within one to four
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_byte_count != '0 && r_byte_count <= COUNT_W'(4)))
        else $error("byte count out of range");

endmodule

// File: test/sample_depth_to_byte_converter_top_tb.sv
// Self-checking testbench for the sample depth to byte converter top level.
`timescale 1ns / 1ps

module sample_depth_to_byte_converter_top_tb;
    import sdbc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCKS      = 17;
    localparam int BLOCK_ITEMS = 50;
    localparam int DRAIN_WAIT  = 4;

    typedef struct packed {
        logic [LAYOUT_W-1:0] layout;
        logic [PREC_W-1:0]   p_first;
        logic [PREC_W-1:0]   p_second;
        logic [PREC_W-1:0]   p_third;
        logic [PREC_W-1:0]   p_alpha;
        logic [FLAGS_W-1:0]  flags;
    } cfg_set_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] s_alpha;
        logic [SAMPLE_W-1:0] s_third;
        logic [SAMPLE_W-1:0] s_second;
        logic [SAMPLE_W-1:0] s_first;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  b_zero;
        logic [BYTE_W-1:0]  b_one;
        logic [BYTE_W-1:0]  b_two;
        logic [BYTE_W-1:0]  b_three;
        logic [COUNT_W-1:0] count;
    } pixel_bytes_t;

    typedef struct packed {
        cfg_set_t     cfg;
        pixel_t       px;
        logic         known;
        pixel_bytes_t bytes;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // sample_first[16:0], sample_second[33:17], sample_third[50:34], sample_alpha[67:51]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // byte_zero[7:0], byte_one[15:8], byte_two[23:16], byte_three[31:24], byte_count[34:32]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    cfg_set_t     cur_cfg;
    pixel_bytes_t pending_bytes[$];
    pixel_bytes_t got_bytes;
    pixel_bytes_t want_bytes;
    dir_row_t     dir_tab[$];
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           snd_idle[4] = '{0, 62, 0, 14};
    int           rcv_stall[4] = '{0, 0, 62, 14};

    sample_depth_to_byte_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_prec(input logic [PREC_W-1:0] p);
        if (p < PREC_MIN) return int'(PREC_MIN);
        if (p > PREC_MAX) return int'(PREC_MAX);
        return int'(p);
    endfunction

    function automatic logic [BYTE_W-1:0] channel_byte(input logic [SAMPLE_W-1:0] smp,
                                                       input int p_first, input int p_chan,
                                                       input logic sgn);
        int v;
        int m;
        int acc;
        int n;
        int sft;
        v = int'($signed(smp));
        if (sgn) v += 1 << (p_chan - 1);
        if (p_first < int'(PREC_BYTE)) begin
            m = v & ((1 << p_first) - 1);
            acc = 0;
            n = 0;
            while (n < 8) begin
                acc = (acc << p_first) | m;
                n += p_first;
            end
            acc = (acc >> (n - 8)) & int'(BYTE_MAX);
            return acc[BYTE_W-1:0];
        end
        if (v < 0) return '0;
        if (p_chan > int'(PREC_BYTE)) begin
            sft = p_chan - int'(PREC_BYTE);
            v = (v >> sft) + ((v >> (sft - 1)) & 1);
        end
        if (v > int'(BYTE_MAX)) v = int'(BYTE_MAX);
        return v[BYTE_W-1:0];
    endfunction

    function automatic pixel_bytes_t pack_pixel(input cfg_set_t c, input pixel_t px);
        logic [BYTE_W-1:0] b[4];
        int k;
        int p0;
        b = '{default: '0};
        k = 0;
        p0 = eff_prec(c.p_first);
        b[k] = channel_byte(px.s_first, p0, p0, c.flags[FLAG_FIRST]);
        k++;
        if (c.layout[LAYOUT_RGB_BIT]) begin
            b[k] = channel_byte(px.s_second, p0, eff_prec(c.p_second), c.flags[FLAG_SECOND]);
            k++;
            b[k] = channel_byte(px.s_third, p0, eff_prec(c.p_third), c.flags[FLAG_THIRD]);
            k++;
        end
        if (c.layout[LAYOUT_ALPHA_BIT]) begin
            b[k] = channel_byte(px.s_alpha, p0, eff_prec(c.p_alpha), c.flags[FLAG_ALPHA]);
            k++;
        end
        return '{b[0], b[1], b[2], b[3], k[COUNT_W-1:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(input int p, input logic sgn);
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom);
            1, 2: begin
                v = int'($urandom_range((1 << p) - 1));
                if (sgn) v -= 1 << (p - 1);
            end
            default: begin
                case ($urandom_range(3))
                    0: v = 0;
                    1: v = (1 << p) - 1;
                    2: v = 1 << (p - 1);
                    default: v = -1 - int'($urandom_range(3));
                endcase
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [PREC_W-1:0] rand_prec();
        if ($urandom_range(9) < 8) return PREC_W'($urandom_range(16, 1));
        return PREC_W'($urandom_range(31));
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
        mismatch_cnt++;
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input cfg_set_t c);
        put_reg(CFG_LAYOUT, CFG_DATA_W'(c.layout));
        put_reg(CFG_FIRST_PREC, c.p_first);
        put_reg(CFG_SECOND_PREC, c.p_second);
        put_reg(CFG_THIRD_PREC, c.p_third);
        put_reg(CFG_ALPHA_PREC, c.p_alpha);
        put_reg(CFG_SIGNED, CFG_DATA_W'(c.flags));
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Returns at the edge that accepted the transaction
    task automatic send_pixel(input pixel_t px, input logic known, input pixel_bytes_t bytes);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 4 * SAMPLE_W){1'b0}}, px};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_bytes.push_back(known ? bytes : pack_pixel(cur_cfg, px));
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_bytes = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                          m_axis_tdata[31:24], m_axis_tdata[34:32]};
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected transaction byte_zero", got_bytes.b_zero, 0);
            end else begin
                want_bytes = pending_bytes.pop_front();
                if (got_bytes.b_zero != want_bytes.b_zero)
                    report_mismatch("byte_zero", got_bytes.b_zero, want_bytes.b_zero);
                if (got_bytes.b_one != want_bytes.b_one)
                    report_mismatch("byte_one", got_bytes.b_one, want_bytes.b_one);
                if (got_bytes.b_two != want_bytes.b_two)
                    report_mismatch("byte_two", got_bytes.b_two, want_bytes.b_two);
                if (got_bytes.b_three != want_bytes.b_three)
                    report_mismatch("byte_three", got_bytes.b_three, want_bytes.b_three);
                if (got_bytes.count != want_bytes.count)
                    report_mismatch("byte_count", got_bytes.count, want_bytes.count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        cfg_set_t c;
        pixel_t   px;
        cur_cfg = '{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0};

        // extremes, every layout, each replication width, signed offsets, out-of-range precisions
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h0, 17'h0, 17'h0, 17'h0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd255}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h0, 17'h0, 17'h0, 17'd256}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h0, 17'h0, 17'h0, 17'h1FFFF}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h0, 17'h0, 17'h0, 17'h10000}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'h0, 17'h0, 17'h0, 17'h0FFFF}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd3, 5'd16, 5'd16, 5'd16, 5'd16, 4'h0},
            '{17'h00180, 17'h0007F, 17'h00080, 17'h0FFFF}, 1'b1, '{8'd255, 8'd1, 8'd0, 8'd2, 3'd4}});
        dir_tab.push_back('{'{2'd1, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd20, 17'd99, 17'd99, 17'd10}, 1'b1, '{8'd10, 8'd20, 8'd0, 8'd0, 3'd2}});
        dir_tab.push_back('{'{2'd2, 5'd8, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd77, 17'd3, 17'd2, 17'd1}, 1'b1, '{8'd1, 8'd2, 8'd3, 8'd0, 3'd3}});
        dir_tab.push_back('{'{2'd3, 5'd1, 5'd1, 5'd1, 5'd1, 4'h0},
            '{17'd0, 17'd1, 17'd0, 17'd1}, 1'b1, '{8'd255, 8'd0, 8'd255, 8'd0, 3'd4}});
        dir_tab.push_back('{'{2'd0, 5'd2, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'd2}, 1'b1, '{8'hAA, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd3, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'd5}, 1'b1, '{8'hB6, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd4, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'h1A}, 1'b1, '{8'hAA, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd5, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'h13}, 1'b1, '{8'h9C, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd6, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'h21}, 1'b1, '{8'h86, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd7, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'h40}, 1'b1, '{8'h81, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd0, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'd1}, 1'b1, '{8'hFF, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd31, 5'd8, 5'd8, 5'd8, 4'h0},
            '{17'd0, 17'd0, 17'd0, 17'h0FFFF}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd3, 5'd8, 5'd8, 5'd8, 5'd8, 4'hF},
            '{17'h1FF7F, 17'h0, 17'h0007F, 17'h1FF80}, 1'b1, '{8'd0, 8'd255, 8'd128, 8'd0, 3'd4}});
        dir_tab.push_back('{'{2'd0, 5'd16, 5'd8, 5'd8, 5'd8, 4'h1},
            '{17'h0, 17'h0, 17'h0, 17'h0}, 1'b1, '{8'd128, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd4, 5'd8, 5'd8, 5'd8, 4'h1},
            '{17'h0, 17'h0, 17'h0, 17'h1FFF8}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd0, 5'd4, 5'd8, 5'd8, 5'd8, 4'h1},
            '{17'h0, 17'h0, 17'h0, 17'h7}, 1'b1, '{8'hFF, 8'd0, 8'd0, 8'd0, 3'd1}});
        dir_tab.push_back('{'{2'd3, 5'd4, 5'd16, 5'd1, 5'd9, 4'hF},
            '{17'h1FFFF, 17'h00001, 17'h18000, 17'h01234}, 1'b0, '0});
        dir_tab.push_back('{'{2'd3, 5'd9, 5'd9, 5'd12, 5'd15, 4'h0},
            '{17'h07FFF, 17'h00ABC, 17'h00101, 17'h001FF}, 1'b0, '0});
        dir_tab.push_back('{'{2'd2, 5'd12, 5'd12, 5'd12, 5'd12, 4'h7},
            '{17'h0, 17'h1F800, 17'h007FF, 17'h10800}, 1'b0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].cfg != cur_cfg) begin
                drain_pipe();
                load_settings(dir_tab[r].cfg);
            end
            send_pixel(dir_tab[r].px, dir_tab[r].known, dir_tab[r].bytes);
        end

        for (int blk = 0; blk < BLOCKS; blk++) begin
            drain_pipe();
            case (blk)
                0: c = '{2'd3, 5'd1, 5'd1, 5'd1, 5'd1, 4'hF};
                1: c = '{2'd3, 5'd16, 5'd16, 5'd16, 5'd16, 4'hF};
                2: c = '{2'd3, 5'd31, 5'd0, 5'd31, 5'd0, 4'h0};
                3: c = '{2'd3, 5'd0, 5'd31, 5'd16, 5'd1, 4'hA};
                default: c = '{LAYOUT_W'($urandom_range(3)), rand_prec(), rand_prec(),
                               rand_prec(), rand_prec(), FLAGS_W'($urandom_range(15))};
            endcase
            load_settings(c);
            idle_pct  = snd_idle[blk % 4];
            stall_pct = rcv_stall[blk % 4];
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                px.s_first  = rand_sample(eff_prec(c.p_first), c.flags[FLAG_FIRST]);
                px.s_second = rand_sample(eff_prec(c.p_second), c.flags[FLAG_SECOND]);
                px.s_third  = rand_sample(eff_prec(c.p_third), c.flags[FLAG_THIRD]);
                px.s_alpha  = rand_sample(eff_prec(c.p_alpha), c.flags[FLAG_ALPHA]);
                send_pixel(px, 1'b0, '0);
            end
        end

        drain_pipe();
        if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sdbc_pkg.sv
rtl/sdbc_channel.sv
rtl/sample_depth_to_byte_converter_top.sv
test/sample_depth_to_byte_converter_top_tb.sv
